// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
// Uses the clock and reset signals of the module it is written in.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/u8u16_pkg.sv =====
// Types and constants shared by the UTF-8 to UTF-16 transcoder modules.
package u8u16_pkg;

   localparam int CODE_W      = 21;   // widest code point from a 4-byte sequence
   localparam int MAX_CODES   = 3;    // code points one byte can release
   localparam int QUEUE_DEPTH = 2;    // default depth of the front/back queue

   localparam logic [CODE_W-1:0] SPACE_CODE = CODE_W'(32);
   localparam logic [CODE_W-1:0] SURR_BASE  = CODE_W'(32'h1_0000);
   localparam logic [15:0]       HI_SURR    = 16'hD800;
   localparam logic [15:0]       LO_SURR    = 16'hDC00;

   // Input item.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [15:0] code_unit;
      logic        run_last;
      logic        string_done;
   } rsp_type;

   // One queue entry: the code points released by one input byte.
   typedef struct packed {
      logic [MAX_CODES-1:0][CODE_W-1:0] codes;
      logic [1:0]                       ncodes;      // 1 to 3
      logic                             string_end;
   } entry_type;

   // Queue status seen by front and back.
   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

endpackage

// ===== rtl/u8u16_front.sv =====
// Front end: accepts bytes, holds unfinished sequences and parses them into code points.
module u8u16_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  u8u16_pkg::req_type           req_data,
   output logic                         push_valid,
   output u8u16_pkg::entry_type         push_data,
   input  u8u16_pkg::queue_status_type  q_status
);

   // Result of parsing the buffered bytes.
   typedef struct packed {
      logic [u8u16_pkg::MAX_CODES-1:0][u8u16_pkg::CODE_W-1:0] codes;
      logic [1:0]                                             ncodes;
   } parse_type;

   logic [2:0][7:0] pend_ff, pend_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic [3:0][7:0] buf_bytes;
   logic [2:0]      buf_len;
   logic [2:0]      lead_need;
   logic            accept;
   logic            emit;
   parse_type       parsed;

   // Sequence length from the lead byte; zero for a lead from 8'hF8 up (continuation bytes give two).
   function automatic logic [2:0] seq_len(input logic [7:0] lead);
      logic [2:0] n;
      if (lead <= 8'h7F)      n = 3'd1;
      else if (lead <= 8'hDF) n = 3'd2;
      else if (lead <= 8'hEF) n = 3'd3;
      else if (lead <= 8'hF7) n = 3'd4;
      else                    n = 3'd0;
      return n;
   endfunction

   // Code point of a complete sequence of the given length.
   function automatic logic [u8u16_pkg::CODE_W-1:0] decode(
      input logic [7:0] b0, input logic [7:0] b1,
      input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] need);
      logic [u8u16_pkg::CODE_W-1:0] c;
      case (need)
         3'd1:    c = {13'd0, b0};
         3'd2:    c = {10'd0, b0[4:0], b1[5:0]};
         3'd3:    c = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
         3'd4:    c = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
         default: c = '0;
      endcase
      return c;
   endfunction

   // Walk the buffer: complete sequences decode, a cut or bad lead gives a space
   // and parsing resumes at the next byte.
   function automatic parse_type parse(input logic [3:0][7:0] bytes, input logic [2:0] len);
      parse_type                    r;
      logic [2:0]                   pos;
      logic [2:0]                   need;
      logic [2:0]                   n;
      logic [1:0]                   p;
      logic [u8u16_pkg::CODE_W-1:0] code;
      r    = '0;
      pos  = '0;
      n    = '0;
      need = '0;
      p    = '0;
      code = '0;
      for (int s = 0; s < 4; s++) begin
         if (pos < len) begin
            p    = pos[1:0];
            need = seq_len(bytes[p]);
            if (need != 3'd0 && ({1'b0, pos} + {1'b0, need}) <= {1'b0, len}) begin
               code = decode(bytes[p], bytes[p + 2'd1], bytes[p + 2'd2], bytes[p + 2'd3],
                             need);
               pos  = pos + need;
            end else begin
               code = u8u16_pkg::SPACE_CODE;
               pos  = pos + 3'd1;
            end
            if (n < 3'd3) begin
               r.codes[n[1:0]] = code;
            end
            n = n + 3'd1;
         end
      end
      r.ncodes = n[1:0];
      return r;
   endfunction

   assign req_ready = q_status.not_full;
   assign accept    = req_valid && req_ready;

   // Held bytes followed by the new one.
   always_comb begin
      buf_bytes[0] = (cnt_ff == 2'd0) ? req_data.in_byte : pend_ff[0];
      buf_bytes[1] = (cnt_ff == 2'd1) ? req_data.in_byte : pend_ff[1];
      buf_bytes[2] = (cnt_ff == 2'd2) ? req_data.in_byte : pend_ff[2];
      buf_bytes[3] = req_data.in_byte;
      buf_len      = {1'b0, cnt_ff} + 3'd1;
      lead_need    = seq_len(buf_bytes[0]);
      emit         = req_data.string_end || (buf_len >= lead_need);
      parsed       = parse(buf_bytes, buf_len);
   end

   // Queue write.
   always_comb begin
      push_valid           = accept && emit;
      push_data.codes      = parsed.codes;
      push_data.ncodes     = parsed.ncodes;
      push_data.string_end = req_data.string_end;
   end

   // Pending sequence update.
   always_comb begin
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         if (emit) begin
            cnt_in = 2'd0;
         end else begin
            for (int k = 0; k < 3; k++) begin
               if (cnt_ff == 2'(k)) pend_in[k] = req_data.in_byte;
            end
            cnt_in = cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/u8u16_queue.sv =====
// Short queue of parsed entries between the front and back ends.
module u8u16_queue #(
   parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  u8u16_pkg::entry_type         push_data,
   input  logic                         pop,
   output u8u16_pkg::entry_type         head,
   output u8u16_pkg::queue_status_type  status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u8u16_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign status.not_empty = (count_ff != '0);
   assign status.not_full  = (count_ff != CNT_W'(DEPTH));
   assign head             = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop)      count_in = count_ff + 1'b1;
      else if (!push_valid && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/u8u16_back.sv =====
// Back end: expands queued code points into UTF-16 units, one per cycle unless rsp_ready stalls.
module u8u16_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         swap_order,
   input  u8u16_pkg::entry_type         head,
   input  u8u16_pkg::queue_status_type  q_status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output u8u16_pkg::rsp_type           rsp_data
);

   logic [1:0]                   idx_ff, idx_in;
   logic                         low_ff, low_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   u8u16_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic [u8u16_pkg::CODE_W-1:0] cur_code;
   logic [u8u16_pkg::CODE_W-1:0] offset;
   logic                         is_pair;
   logic [15:0]                  raw_unit;
   logic                         code_last;
   logic                         entry_last;
   logic                         load;

   // Current code point and the unit it gives now.
   always_comb begin
      case (idx_ff)
         2'd0:    cur_code = head.codes[0];
         2'd1:    cur_code = head.codes[1];
         2'd2:    cur_code = head.codes[2];
         default: cur_code = head.codes[0];
      endcase
      is_pair = |cur_code[u8u16_pkg::CODE_W-1:16];
      offset  = cur_code - u8u16_pkg::SURR_BASE;
      if (!is_pair)     raw_unit = cur_code[15:0];
      else if (!low_ff) raw_unit = u8u16_pkg::HI_SURR | {6'd0, offset[19:10]};
      else              raw_unit = u8u16_pkg::LO_SURR | {6'd0, offset[9:0]};
      code_last  = !is_pair || low_ff;
      entry_last = code_last && (idx_ff == head.ncodes - 2'd1);
   end

   // Output register loads when the queue holds an entry and the register is empty or being drained.
   always_comb begin
      load         = q_status.not_empty && (!rsp_valid_ff || rsp_ready);
      pop          = load && entry_last;
      idx_in       = idx_ff;
      low_in       = low_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.code_unit   = swap_order ? {raw_unit[7:0], raw_unit[15:8]} : raw_unit;
         rsp_data_in.run_last    = entry_last;
         rsp_data_in.string_done = entry_last && head.string_end;
         if (entry_last) begin
            idx_in = 2'd0;
            low_in = 1'b0;
         end else if (code_last) begin
            idx_in = idx_ff + 2'd1;
            low_in = 1'b0;
         end else begin
            low_in = 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         idx_ff       <= 2'd0;
         low_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/utf8_to_utf16_transcoder_unit.sv =====
// Top level of the UTF-8 to UTF-16 transcoder: front end, queue and back end.
// The completing byte's code points pass through the queue and then the output register.
// Throughput: one byte per cycle while the queue is not full; the back end sends one unit per
// cycle unless rsp_ready stalls it, so a byte's units occupy the output in turn, buffered by a
// QUEUE_DEPTH-entry queue. Bytes that only extend a pending sequence produce no result.
// Reset (synchronous): clears pending bytes count, queue, output valid and swap_order.
module utf8_to_utf16_transcoder_unit #(
   parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  u8u16_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output u8u16_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_data
);

   logic                        swap_order_ff, swap_order_in;
   logic                        push_valid;
   u8u16_pkg::entry_type        push_data;
   logic                        pop;
   u8u16_pkg::entry_type        head;
   u8u16_pkg::queue_status_type q_status;

   // Byte swap register.
   assign csr_ready     = 1'b1;
   assign swap_order_in = (csr_valid && csr_ready) ? csr_data : swap_order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_order_ff <= 1'b0;
      end else begin
         swap_order_ff <= swap_order_in;
      end
   end

   u8u16_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_data  (push_data),
      .q_status   (q_status)
   );

   u8u16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   u8u16_back u_back (
      .clock      (clock),
      .reset      (reset),
      .swap_order (swap_order_ff),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/u8u16_checker.sv =====
// Port-level checker for the transcoder, bound to the top level.
`include "assert_macros.svh"

module u8u16_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input u8u16_pkg::rsp_type  rsp_data
);

   // A stalled result item stays offered.
   `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped while stalled")

   // A stalled result item keeps its payload.
   `ASSERT_CLK(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp data unstable")

   // The end of a string always closes the run of its byte.
   `ASSERT_CLK(a_done, rsp_valid && rsp_data.string_done |-> rsp_data.run_last, "done not last")

   // No result item is offered right after reset.
   `ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "rsp_valid after reset")

endmodule

bind utf8_to_utf16_transcoder_unit u8u16_checker u_checker (.*);
